### hdl/prh_pkg.sv
// Shared types and constants of the Preisach relay hysteresis block.
`default_nettype none

package prh_pkg;

    localparam int OPCODE_W   = 2;
    localparam int INDEX_W    = 6;
    localparam int OUT_W      = 32;
    localparam int ACTIVE_W   = 7;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [OPCODE_W-1:0] OP_SAMPLE  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_LOAD    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_RESTART = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_ACTIVE_RELAYS   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MEMORYLESS_MODE = 2'd1;

    typedef struct packed {
        logic load_wr;
        logic clear_wr;
        logic rd_en;
        logic cnt_clr;
        logic cnt_inc;
        logic sample_start;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic n_zero;
        logic run_last;
        logic clear_last;
    } status_t;

endpackage

`default_nettype wire

### hdl/prh_datapath.sv
// Datapath: configuration registers, relay tables, relay state memory and accumulator.
`default_nettype none

module prh_datapath #(
    parameter int MAX_RELAYS  = 64,
    parameter int VALUE_WIDTH = 24
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  prh_pkg::cmd_t                        cmd,
    output prh_pkg::status_t                     status,
    input  wire                                  cfg_valid,
    input  wire  [prh_pkg::CFG_ADDR_W-1:0]       cfg_index,
    input  wire  [prh_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire  [prh_pkg::INDEX_W-1:0]          s_relay_index,
    input  wire  signed [VALUE_WIDTH-1:0]        s_displacement,
    input  wire  signed [VALUE_WIDTH-1:0]        s_upper_threshold,
    input  wire  signed [VALUE_WIDTH-1:0]        s_lower_threshold,
    input  wire  signed [VALUE_WIDTH-1:0]        s_relay_weight,
    output logic signed [prh_pkg::OUT_W-1:0]     m_model_output
);

    localparam int IDX_W   = (MAX_RELAYS > 1) ? $clog2(MAX_RELAYS) : 1;
    localparam int CNT_W   = $clog2(MAX_RELAYS + 1);
    localparam int N_W     = (CNT_W > prh_pkg::ACTIVE_W) ? CNT_W : prh_pkg::ACTIVE_W;
    localparam int ENTRY_W = 3 * VALUE_WIDTH;

    logic [prh_pkg::ACTIVE_W-1:0] active_reg;
    logic                         mode_reg;
    logic [IDX_W-1:0]             cnt_reg;
    logic signed [VALUE_WIDTH-1:0] x_reg;
    logic [ENTRY_W-1:0]           tab_mem [MAX_RELAYS];
    logic                         st_mem [MAX_RELAYS];
    logic [ENTRY_W-1:0]           tab_rd_reg;
    logic                         st_rd_reg;
    logic                         proc_valid_reg;
    logic [IDX_W-1:0]             proc_addr_reg;
    logic [prh_pkg::OUT_W-1:0]    acc_reg;
    logic [prh_pkg::OUT_W-1:0]    acc_next;
    logic [prh_pkg::OUT_W-1:0]    out_reg;

    logic [N_W-1:0]               active_ext;
    logic [N_W-1:0]               n_relays;
    logic [31:0]                  load_idx_ext;
    logic [IDX_W-1:0]             load_addr;
    logic                         load_in_range;
    logic signed [VALUE_WIDTH-1:0] rd_upper;
    logic signed [VALUE_WIDTH-1:0] rd_lower;
    logic signed [VALUE_WIDTH-1:0] rd_weight;
    logic signed [prh_pkg::OUT_W-1:0] weight_ext;
    logic                         at_upper;
    logic                         at_lower;
    logic                         new_state;
    logic                         add_term;
    logic                         sub_term;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
            mode_reg   <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                prh_pkg::CFG_ACTIVE_RELAYS: begin
                    active_reg <= cfg_data[prh_pkg::ACTIVE_W-1:0];
                end
                prh_pkg::CFG_MEMORYLESS_MODE: begin
                    mode_reg <= cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign active_ext = N_W'(active_reg);
    assign n_relays   = (active_ext > N_W'(MAX_RELAYS)) ? N_W'(MAX_RELAYS) : active_ext;

    assign status.n_zero     = (n_relays == '0);
    assign status.run_last   = ((N_W'(cnt_reg) + N_W'(1)) == n_relays);
    assign status.clear_last = (cnt_reg == IDX_W'(MAX_RELAYS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= '0;
            proc_valid_reg <= 1'b0;
        end else begin
            if (cmd.cnt_clr) begin
                cnt_reg <= '0;
            end else if (cmd.cnt_inc) begin
                cnt_reg <= cnt_reg + IDX_W'(1);
            end
            proc_valid_reg <= cmd.rd_en;
        end
    end

    assign load_idx_ext  = 32'(s_relay_index);
    assign load_addr     = load_idx_ext[IDX_W-1:0];
    assign load_in_range = (load_idx_ext < 32'(MAX_RELAYS));

    always_ff @(posedge aclk) begin
        if (cmd.load_wr && load_in_range) begin
            tab_mem[load_addr] <= {s_upper_threshold, s_lower_threshold, s_relay_weight};
        end
        if (cmd.rd_en) begin
            tab_rd_reg <= tab_mem[cnt_reg];
        end
    end

    assign rd_upper   = $signed(tab_rd_reg[3*VALUE_WIDTH-1:2*VALUE_WIDTH]);
    assign rd_lower   = $signed(tab_rd_reg[2*VALUE_WIDTH-1:VALUE_WIDTH]);
    assign rd_weight  = $signed(tab_rd_reg[VALUE_WIDTH-1:0]);
    assign weight_ext = prh_pkg::OUT_W'(rd_weight);

    assign at_upper  = (x_reg >= rd_upper);
    assign at_lower  = (x_reg <= rd_lower);
    assign new_state = at_upper ? 1'b1 : (at_lower ? 1'b0 : st_rd_reg);

    always_comb begin
        if (mode_reg) begin
            add_term = at_upper;
            sub_term = !at_upper && at_lower;
        end else begin
            add_term = new_state;
            sub_term = !new_state;
        end
        if (add_term) begin
            acc_next = acc_reg + weight_ext;
        end else if (sub_term) begin
            acc_next = acc_reg - weight_ext;
        end else begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear_wr) begin
            st_mem[cnt_reg] <= 1'b0;
        end else if (proc_valid_reg && !mode_reg) begin
            st_mem[proc_addr_reg] <= new_state;
        end
        if (cmd.rd_en) begin
            st_rd_reg <= st_mem[cnt_reg];
        end
    end

    always_ff @(posedge aclk) begin
        proc_addr_reg <= cnt_reg;
        if (cmd.sample_start) begin
            x_reg   <= s_displacement;
            acc_reg <= '0;
        end else if (proc_valid_reg) begin
            acc_reg <= acc_next;
        end
        if (cmd.out_load) begin
            out_reg <= acc_reg;
        end
    end

    assign m_model_output = $signed(out_reg);

endmodule

`default_nettype wire

### hdl/prh_controller.sv
// Controller: state machine that sequences load, restart, clearing and sample walks.
`default_nettype none

module prh_controller (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_valid,
    output logic                            s_ready,
    input  wire  [prh_pkg::OPCODE_W-1:0]    s_opcode,
    output logic                            m_valid,
    input  wire                             m_ready,
    input  prh_pkg::status_t                status,
    output prh_pkg::cmd_t                   cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_FLUSH = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_valid_reg;
    logic       in_accept;

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign m_valid   = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                cmd.cnt_inc  = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    case (s_opcode)
                        prh_pkg::OP_LOAD: begin
                            cmd.load_wr = 1'b1;
                        end
                        prh_pkg::OP_RESTART: begin
                            cmd.cnt_clr = 1'b1;
                            state_next  = ST_CLEAR;
                        end
                        prh_pkg::OP_SAMPLE: begin
                            cmd.cnt_clr      = 1'b1;
                            cmd.sample_start = 1'b1;
                            state_next       = status.n_zero ? ST_DONE : ST_RUN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                cmd.rd_en   = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (status.run_last) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/preisach_relay_hysteresis.sv
// Top level of the Preisach relay hysteresis block.
//
//  Channel  Ports                         Direction  Moves
//  s_       s_valid/s_ready + fields      in         one item: sample, load or restart
//  m_       m_valid/m_ready + output      out        one item: weighted relay sum
//  cfg_     cfg_valid/cfg_ready + idx/data in        one register write, always ready
//
// A load item is written into the relay table as it is taken. A sample item walks the active
// relays, their count capped at MAX_RELAYS (no walk when no relay is active), one relay per cycle
// through the table and state memory read ports, plus any wait for m_ready.
// A restart item clears every state memory entry, one entry cleared per cycle.
// After reset the same clearing pass runs with s_ready low.
// A new item is taken while a finished result still waits in the output register.
`default_nettype none

module preisach_relay_hysteresis #(
    parameter int MAX_RELAYS  = 64,
    parameter int VALUE_WIDTH = 24
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [prh_pkg::CFG_ADDR_W-1:0]       cfg_index,
    input  wire  [prh_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire  [prh_pkg::OPCODE_W-1:0]         s_opcode,
    input  wire  [prh_pkg::INDEX_W-1:0]          s_relay_index,
    input  wire  signed [VALUE_WIDTH-1:0]        s_displacement,
    input  wire  signed [VALUE_WIDTH-1:0]        s_upper_threshold,
    input  wire  signed [VALUE_WIDTH-1:0]        s_lower_threshold,
    input  wire  signed [VALUE_WIDTH-1:0]        s_relay_weight,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic signed [prh_pkg::OUT_W-1:0]     m_model_output
);

    prh_pkg::cmd_t    cmd;
    prh_pkg::status_t status;

    assign cfg_ready = 1'b1;

    prh_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .status   (status),
        .cmd      (cmd)
    );

    prh_datapath #(
        .MAX_RELAYS  (MAX_RELAYS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_relay_index     (s_relay_index),
        .s_displacement    (s_displacement),
        .s_upper_threshold (s_upper_threshold),
        .s_lower_threshold (s_lower_threshold),
        .s_relay_weight    (s_relay_weight),
        .m_model_output    (m_model_output)
    );

endmodule

`default_nettype wire

### hdl/prh_checker.sv
// Port-level checker of the Preisach relay hysteresis block and its bind.
`default_nettype none

module prh_checker (
    input wire                               aclk,
    input wire                               aresetn,
    input wire                               s_valid,
    input wire                               s_ready,
    input wire [prh_pkg::OPCODE_W-1:0]       s_opcode,
    input wire                               m_valid,
    input wire                               m_ready,
    input wire [prh_pkg::OUT_W-1:0]          m_model_output
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_model_output))
        else $error("Stalled result item changed or dropped.");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("Input accepted before the clearing pass after reset.");

    a_busy_after_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_opcode == prh_pkg::OP_SAMPLE || s_opcode == prh_pkg::OP_RESTART)
        |=> !s_ready)
        else $error("Ready stayed high after a sample or restart item.");

    a_load_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_opcode == prh_pkg::OP_LOAD |=> s_ready)
        else $error("Load item did not complete in one cycle.");

    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("Result item appeared without a sample walk.");

endmodule

bind preisach_relay_hysteresis prh_checker u_prh_checker (.*);

`default_nettype wire
